// ===== rtl/voxel_hull_face_extractor_macros.svh =====
// assertion macros for the voxel hull face extractor checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef VOXEL_HULL_FACE_EXTRACTOR_MACROS_SVH
`define VOXEL_HULL_FACE_EXTRACTOR_MACROS_SVH

// property that must hold at every edge outside reset
`define VHFE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("vhfe assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define VHFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vhfe assertion failed");

`endif

// ===== rtl/vhfe_pkg.sv =====
// shared types, codes and constants of the voxel hull face extractor
// no dependencies
`default_nettype none

package vhfe_pkg;

    localparam int GRID_X_DEF = 32;
    localparam int GRID_Y_DEF = 32;
    localparam int GRID_Z_DEF = 32;

    localparam logic [1:0] OP_SET_OCC  = 2'd0;
    localparam logic [1:0] OP_SET_COL  = 2'd1;
    localparam logic [1:0] OP_VISIT    = 2'd2;
    localparam logic [1:0] OP_NEW_MESH = 2'd3;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [5:0]  SIZE_RESET = 6'd32;
    localparam logic [19:0] VCOUNT_MAX = 20'd1048572;
    localparam logic [19:0] VCOUNT_STEP = 20'd4;

    typedef struct packed {
        logic [1:0] op;
        logic       wr_ok;
        logic       occupied;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
        logic       ctr_ok;
        logic [5:0] nb_ok;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_sts;

    function automatic logic [5:0] eff_size(input logic [5:0] s, input int grid);
        logic [5:0] r;
        r = s;
        if (int'(s) > grid) begin
            r = 6'(grid);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vhfe_front.sv =====
// front end: size registers, command decode, flat index and range checks
// depends on vhfe_pkg
`default_nettype none

module vhfe_front #(
    parameter int GRID_X = vhfe_pkg::GRID_X_DEF,
    parameter int GRID_Y = vhfe_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vhfe_pkg::GRID_Z_DEF,
    parameter int IW     = $clog2(GRID_X * GRID_Y * GRID_Z)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [5:0]     i_cfg_data,
    input  wire logic [1:0]     i_op,
    input  wire logic [14:0]    i_voxel_index,
    input  wire logic           i_occupied,
    input  wire logic [7:0]     i_red,
    input  wire logic [7:0]     i_green,
    input  wire logic [7:0]     i_blue,
    input  wire logic [4:0]     i_coord_x,
    input  wire logic [4:0]     i_coord_y,
    input  wire logic [4:0]     i_coord_z,
    output vhfe_pkg::t_cmd      o_cmd,
    output logic [IW-1:0]       o_idx,
    output logic [IW-1:0]       o_sx,
    output logic [IW-1:0]       o_sxy
);

    localparam int unsigned DEPTH = GRID_X * GRID_Y * GRID_Z;

    logic [5:0]    r_size_x, r_size_y, r_size_z;
    logic [IW-1:0] r_sxy;
    logic [IW-1:0] n_sxy;
    logic [5:0]    ex, ey, ez;
    logic [5:0]    cx, cy, cz;

    assign ex = vhfe_pkg::eff_size(r_size_x, GRID_X);
    assign ey = vhfe_pkg::eff_size(r_size_y, GRID_Y);
    assign ez = vhfe_pkg::eff_size(r_size_z, GRID_Z);

    // plane stride follows the write so it is ready on the next edge
    always_comb begin
        n_sxy = r_sxy;
        if (i_cfg_we && i_cfg_idx == vhfe_pkg::CFG_SIZE_X) begin
            n_sxy = IW'(vhfe_pkg::eff_size(i_cfg_data, GRID_X) * ey);
        end else if (i_cfg_we && i_cfg_idx == vhfe_pkg::CFG_SIZE_Y) begin
            n_sxy = IW'(ex * vhfe_pkg::eff_size(i_cfg_data, GRID_Y));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= vhfe_pkg::SIZE_RESET;
            r_size_y <= vhfe_pkg::SIZE_RESET;
            r_size_z <= vhfe_pkg::SIZE_RESET;
            r_sxy    <= IW'(vhfe_pkg::eff_size(vhfe_pkg::SIZE_RESET, GRID_X)
                            * vhfe_pkg::eff_size(vhfe_pkg::SIZE_RESET, GRID_Y));
        end else begin
            r_sxy <= n_sxy;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vhfe_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data;
                    vhfe_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data;
                    vhfe_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign cx = {1'b0, i_coord_x};
    assign cy = {1'b0, i_coord_y};
    assign cz = {1'b0, i_coord_z};

    always_comb begin
        o_cmd.op       = i_op;
        o_cmd.wr_ok    = (32'(i_voxel_index) < DEPTH);
        o_cmd.occupied = i_occupied;
        o_cmd.red      = i_red;
        o_cmd.green    = i_green;
        o_cmd.blue     = i_blue;
        o_cmd.x        = i_coord_x;
        o_cmd.y        = i_coord_y;
        o_cmd.z        = i_coord_z;
        o_cmd.ctr_ok   = (cx < ex) && (cy < ey) && (cz < ez);
        o_cmd.nb_ok[0] = (i_coord_x != 5'd0);
        o_cmd.nb_ok[1] = ((cx + 6'd1) < ex);
        o_cmd.nb_ok[2] = (i_coord_y != 5'd0);
        o_cmd.nb_ok[3] = ((cy + 6'd1) < ey);
        o_cmd.nb_ok[4] = (i_coord_z != 5'd0);
        o_cmd.nb_ok[5] = ((cz + 6'd1) < ez);
    end

    // visits use the coordinate index, writes the flat index as given;
    // modular arithmetic is exact for in-range voxels
    always_comb begin
        if (i_op == vhfe_pkg::OP_VISIT) begin
            o_idx = IW'(i_coord_x) + IW'(ex) * IW'(i_coord_y) + r_sxy * IW'(i_coord_z);
        end else begin
            o_idx = IW'(i_voxel_index);
        end
    end

    assign o_sx  = IW'(ex);
    assign o_sxy = r_sxy;

endmodule

`default_nettype wire

// ===== rtl/vhfe_queue.sv =====
// two-entry command queue between front and back
// depends on nothing
`default_nettype none

module vhfe_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty,
    output logic                  o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

`default_nettype wire

// ===== rtl/vhfe_back.sv =====
// back end: occupancy and colour memories, visit sequencer, face output
// depends on vhfe_pkg
`default_nettype none

module vhfe_back #(
    parameter int GRID_X = vhfe_pkg::GRID_X_DEF,
    parameter int GRID_Y = vhfe_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vhfe_pkg::GRID_Z_DEF,
    parameter int IW     = $clog2(GRID_X * GRID_Y * GRID_Z)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_avail,
    input  wire vhfe_pkg::t_cmd  i_cmd,
    input  wire logic [IW-1:0]   i_idx,
    input  wire logic [IW-1:0]   i_sx,
    input  wire logic [IW-1:0]   i_sxy,
    output logic                 o_pop,
    output vhfe_pkg::t_back_sts  o_sts,
    output logic                 o_valid,
    output logic [2:0]           o_face_dir,
    output logic [4:0]           o_face_x,
    output logic [4:0]           o_face_y,
    output logic [4:0]           o_face_z,
    output logic [7:0]           o_face_red,
    output logic [7:0]           o_face_green,
    output logic [7:0]           o_face_blue,
    output logic [19:0]          o_first_vertex,
    output logic                 o_last
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic          occ_mem [DEPTH];
    logic [23:0]   col_mem [DEPTH];

    logic [2:0]     r_state, n_state;
    logic [IW-1:0]  r_clr_addr;
    logic [19:0]    r_vcnt, n_vcnt;
    logic           r_valid;
    logic           r_rd_v;
    logic [2:0]     r_rd_k;
    logic [2:0]     r_k;
    vhfe_pkg::t_cmd r_cur;
    logic [IW-1:0]  r_idx;
    logic [5:0]     r_mask, n_mask;
    logic           r_ctr_occ;
    logic [23:0]    r_col;
    logic           r_occ_q;
    logic [23:0]    r_col_q;

    logic           occ_we, col_we;
    logic [IW-1:0]  wr_addr;
    logic           wr_occ;
    logic [23:0]    wr_col;
    logic [IW-1:0]  rd_addr;
    logic [2:0]     sel;
    logic [5:0]     rem;
    logic           emit;

    assign o_pop = (r_state == S_IDLE) && i_avail;
    assign emit  = (r_state == S_EMIT);
    assign o_sts.clearing = (r_state == S_CLEAR);

    // memory write side: clearing pass or a queued write command
    always_comb begin
        occ_we  = 1'b0;
        col_we  = 1'b0;
        wr_addr = i_idx;
        wr_occ  = i_cmd.occupied;
        wr_col  = {i_cmd.red, i_cmd.green, i_cmd.blue};
        if (r_state == S_CLEAR) begin
            occ_we  = 1'b1;
            col_we  = 1'b1;
            wr_addr = r_clr_addr;
            wr_occ  = 1'b0;
            wr_col  = 24'd0;
        end else if (o_pop && i_cmd.wr_ok) begin
            occ_we = (i_cmd.op == vhfe_pkg::OP_SET_OCC);
            col_we = (i_cmd.op == vhfe_pkg::OP_SET_COL);
        end
    end

    // center first, then the six neighbours in face order
    always_comb begin
        case (r_k)
            3'd1:    rd_addr = r_idx - IW'(1);
            3'd2:    rd_addr = r_idx + IW'(1);
            3'd3:    rd_addr = r_idx - i_sx;
            3'd4:    rd_addr = r_idx + i_sx;
            3'd5:    rd_addr = r_idx - i_sxy;
            3'd6:    rd_addr = r_idx + i_sxy;
            default: rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            occ_mem[wr_addr] <= wr_occ;
        end
        r_occ_q <= occ_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            col_mem[wr_addr] <= wr_col;
        end
        r_col_q <= col_mem[rd_addr];
    end

    // exposed mask: a neighbour that is outside or empty shows its face
    always_comb begin
        n_mask = r_mask;
        for (int d = 0; d < 6; d++) begin
            if (r_rd_v && r_rd_k == 3'(d + 1)) begin
                n_mask[d] = !(r_cur.nb_ok[d] && r_occ_q);
            end
        end
        if (emit) begin
            n_mask = rem;
        end
    end

    always_comb begin
        sel = 3'd0;
        for (int d = 5; d >= 0; d--) begin
            if (r_mask[d]) begin
                sel = 3'(d);
            end
        end
        rem = r_mask & ~(6'd1 << sel);
    end

    always_comb begin
        n_vcnt = r_vcnt;
        if (emit) begin
            n_vcnt = (r_vcnt >= vhfe_pkg::VCOUNT_MAX - vhfe_pkg::VCOUNT_STEP)
                   ? vhfe_pkg::VCOUNT_MAX : r_vcnt + vhfe_pkg::VCOUNT_STEP;
        end else if (o_pop && i_cmd.op == vhfe_pkg::OP_NEW_MESH) begin
            n_vcnt = 20'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop && i_cmd.op == vhfe_pkg::OP_VISIT && i_cmd.ctr_ok) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_k == 3'd6) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = (r_ctr_occ && n_mask != 6'd0) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (rem == 6'd0) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_vcnt     <= 20'd0;
            r_valid    <= 1'b0;
            r_rd_v     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vcnt  <= n_vcnt;
            r_valid <= emit;
            r_rd_v  <= (r_state == S_READ);
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
        r_mask <= n_mask;
        if (r_state == S_READ) begin
            r_k <= r_k + 3'd1;
        end
        if (o_pop) begin
            r_cur  <= i_cmd;
            r_idx  <= i_idx;
            r_k    <= 3'd0;
            r_mask <= 6'd0;
        end
        if (r_rd_v && r_rd_k == 3'd0) begin
            r_ctr_occ <= r_occ_q;
            r_col     <= r_col_q;
        end
        if (emit) begin
            o_face_dir     <= sel;
            o_face_x       <= r_cur.x;
            o_face_y       <= r_cur.y;
            o_face_z       <= r_cur.z;
            o_face_red     <= r_col[23:16];
            o_face_green   <= r_col[15:8];
            o_face_blue    <= r_col[7:0];
            o_first_vertex <= r_vcnt;
            o_last         <= (rem == 6'd0);
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== rtl/voxel_hull_face_extractor.sv =====
// top level of the voxel hull face extractor
// depends on vhfe_pkg, vhfe_front, vhfe_queue, vhfe_back
`default_nettype none

// A command is taken when start is high and busy is low; ops 0, 1 and 3 are
// carried out as the back end pops them, while a visit to an in-range voxel
// makes seven occupancy reads one after another through the single read port
// of the occupancy memory, registers the read data, decides which faces are
// exposed and emits those of an occupied voxel. Faces of one visit come on
// consecutive cycles, each valid for one cycle only with no way to hold them,
// the final one marked by o_last. A two-entry queue lets the front keep taking
// commands while a visit runs, until the queue is full. After reset busy stays
// high while both memories are cleared; size writes are taken then too.
module voxel_hull_face_extractor #(
    parameter int GRID_X = vhfe_pkg::GRID_X_DEF,
    parameter int GRID_Y = vhfe_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vhfe_pkg::GRID_Z_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [5:0]  i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [14:0] i_voxel_index,
    input  wire logic        i_occupied,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [4:0]  i_coord_x,
    input  wire logic [4:0]  i_coord_y,
    input  wire logic [4:0]  i_coord_z,
    output logic             o_valid,
    output logic [2:0]       o_face_dir,
    output logic [4:0]       o_face_x,
    output logic [4:0]       o_face_y,
    output logic [4:0]       o_face_z,
    output logic [7:0]       o_face_red,
    output logic [7:0]       o_face_green,
    output logic [7:0]       o_face_blue,
    output logic [19:0]      o_first_vertex,
    output logic             o_last
);

    localparam int IW = $clog2(GRID_X * GRID_Y * GRID_Z);
    localparam int QW = $bits(vhfe_pkg::t_cmd) + IW;

    vhfe_pkg::t_cmd      f_cmd, q_cmd;
    logic [IW-1:0]       f_idx, q_idx;
    logic [IW-1:0]       sx, sxy;
    logic                q_empty, q_full, pop, push;
    vhfe_pkg::t_back_sts sts;

    assign push = start && !busy;
    assign busy = q_full || sts.clearing;

    vhfe_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .IW(IW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_voxel_index (i_voxel_index),
        .i_occupied    (i_occupied),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .o_cmd         (f_cmd),
        .o_idx         (f_idx),
        .o_sx          (sx),
        .o_sxy         (sxy)
    );

    vhfe_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_idx}),
        .i_pop   (pop),
        .o_data  ({q_cmd, q_idx}),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    vhfe_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .IW(IW)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (!q_empty),
        .i_cmd          (q_cmd),
        .i_idx          (q_idx),
        .i_sx           (sx),
        .i_sxy          (sxy),
        .o_pop          (pop),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_face_dir     (o_face_dir),
        .o_face_x       (o_face_x),
        .o_face_y       (o_face_y),
        .o_face_z       (o_face_z),
        .o_face_red     (o_face_red),
        .o_face_green   (o_face_green),
        .o_face_blue    (o_face_blue),
        .o_first_vertex (o_first_vertex),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/vhfe_checker.sv =====
// port-level checker for the voxel hull face extractor, bound to the top level
// depends on vhfe_pkg and voxel_hull_face_extractor_macros.svh
`default_nettype none
`include "voxel_hull_face_extractor_macros.svh"

module vhfe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_last,
    input wire logic [2:0]  i_face_dir,
    input wire logic [4:0]  i_face_x,
    input wire logic [4:0]  i_face_y,
    input wire logic [4:0]  i_face_z,
    input wire logic [19:0] i_first_vertex
);

    logic [14:0] xyz;
    logic [19:0] vtx_step;
    logic        vtx_sat;

    assign xyz      = {i_face_x, i_face_y, i_face_z};
    assign vtx_step = i_first_vertex + vhfe_pkg::VCOUNT_STEP;
    assign vtx_sat  = (i_first_vertex == vhfe_pkg::VCOUNT_MAX);

    `VHFE_ASSERT_ALWAYS(a_dir_range, !i_valid || i_face_dir <= 3'd5)
    `VHFE_ASSERT_NEXT(a_faces_packed, i_valid && !i_last, i_valid)
    `VHFE_ASSERT_NEXT(a_same_voxel, i_valid && !i_last, $stable(xyz))
    `VHFE_ASSERT_NEXT(a_dir_rising, i_valid && !i_last, i_face_dir > $past(i_face_dir))
    `VHFE_ASSERT_NEXT(a_vertex_step, i_valid && !i_last, i_first_vertex == $past(vtx_step) || vtx_sat)

endmodule

bind voxel_hull_face_extractor vhfe_checker u_vhfe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_valid),
    .i_last         (o_last),
    .i_face_dir     (o_face_dir),
    .i_face_x       (o_face_x),
    .i_face_y       (o_face_y),
    .i_face_z       (o_face_z),
    .i_first_vertex (o_first_vertex)
);

`default_nettype wire
